### design/bounded_array_list_top_macros.svh
// Assertion macros for the bounded array list.
// Each macro takes a label, an antecedent and a consequent, sampled on i_clk
// and disabled while i_rst_n is low.
`ifndef BOUNDED_ARRAY_LIST_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_TOP_MACROS_SVH

`ifndef SYNTH
`define BAL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bounded array list: same-cycle check failed");
`define BAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bounded array list: next-cycle check failed");
`else
`define BAL_ASSERT_IMPL(label, ante, cons)
`define BAL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/bal_pkg.sv
`default_nettype none
package bal_pkg;

    localparam int CMD_W = 4;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ADD_AT       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_FIRST    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_LAST     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_AT    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_LAST  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_GET_AT       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_GET_FIRST    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_GET_LAST     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CLEAR        = 4'd9;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
    localparam logic [VAL_W-1:0] RV_INVALID = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] RV_NONE    = 32'h0000_0000;

endpackage
`default_nettype wire

### design/bal_ram.sv
`default_nettype none
module bal_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [AW-1:0]         i_waddr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]         i_raddr,
    output logic      [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/bounded_array_list_top.sv
`default_nettype none
`include "bounded_array_list_top_macros.svh"
// Bounded array list: an ordered list of signed values held in one slot RAM.
// Request channel: drive i_command, i_position and i_value with start high;
// the request is taken at a clock edge where start is high and busy is low.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_read_value, o_item_count, o_is_full and o_is_empty; the receiver cannot
// stall it, so it must take the result in that cycle.
// Sequencing: rejected requests, clear, append at the end and removal of the
// last entry finish straight from idle; get passes through S_GET for one RAM read.
// Insert at index p runs S_UP, S_UP_LAST and S_PUT; removal at p runs S_DN
// and S_DN_LAST: the shift moves one entry per cycle through the
// single RAM write port, reading one slot ahead. The longest operation is
// an insert at index 0 into 63 entries. busy stays high until the result shows.
// Configuration: i_cfg_wen writes the capacity from i_cfg_wdata; write it
// only while busy is low. Reset (synchronous, active low) empties the list
// and sets the capacity to 64; slot contents are not cleared, and no
// clearing pass runs, so the block takes requests right after reset.
module bounded_array_list_top
    import bal_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wen,
    input  wire logic        [CNT_W-1:0] i_cfg_wdata,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic        [CMD_W-1:0] i_command,
    input  wire logic        [POS_W-1:0] i_position,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_done,
    output logic             [ST_W-1:0]  o_status,
    output logic signed      [VAL_W-1:0] o_read_value,
    output logic             [CNT_W-1:0] o_item_count,
    output logic                         o_is_full,
    output logic                         o_is_empty
);

    localparam int AW        = $clog2(DEPTH);
    localparam int CAP_LIMIT = (DEPTH < 127) ? DEPTH : 127;
    localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_LAST,
        S_PUT,
        S_DN,
        S_DN_LAST,
        S_GET
    } t_state;

    t_state                r_state, n_state;
    logic                  r_busy;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cap;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_src, n_src;
    logic [AW-1:0]         r_wa, n_wa;
    logic [AW-1:0]         r_last, n_last;
    logic                  r_pend, n_pend;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic                  r_done, n_done;
    logic [ST_W-1:0]       r_status, n_status;
    logic [VAL_W-1:0]      r_rv, n_rv;
    logic [CNT_W-1:0]      r_item_count;
    logic                  r_full, r_empty;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [DATA_WIDTH-1:0] mem_wd, mem_rd;

    logic [CNT_W-1:0]      eff_cap;
    logic [CNT_W-1:0]      idx;
    logic                  in_range;

    bal_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rd)
    );

    assign eff_cap = (r_cap > CAP_LIM) ? CAP_LIM : r_cap;

    // Resolve the target index of the request.
    always_comb begin
        case (i_command)
            CMD_ADD_FIRST, CMD_REMOVE_FIRST, CMD_GET_FIRST: idx = '0;
            CMD_ADD_LAST:                                   idx = r_count;
            CMD_REMOVE_LAST, CMD_GET_LAST:                  idx = r_count - 7'd1;
            default:                                        idx = i_position;
        endcase
    end

    assign in_range = (r_count != '0) && (idx < r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_src    = r_src;
        n_wa     = r_wa;
        n_last   = r_last;
        n_pend   = r_pend;
        n_val    = r_val;
        n_done   = 1'b0;
        n_status = r_status;
        n_rv     = RV_NONE;
        mem_we   = 1'b0;
        mem_wa   = r_wa;
        mem_wd   = mem_rd;
        mem_ra   = r_src;

        unique case (r_state)
            S_IDLE: begin
                mem_ra = AW'(idx);
                if (start) begin
                    case (i_command)
                        CMD_ADD_AT, CMD_ADD_FIRST, CMD_ADD_LAST: begin
                            if (idx > r_count) begin
                                n_done   = 1'b1;
                                n_status = ST_INVALID;
                            end else if (r_count >= eff_cap) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else if (idx == r_count) begin
                                // append: no entries to move
                                mem_we   = 1'b1;
                                mem_wa   = AW'(idx);
                                mem_wd   = DATA_WIDTH'($unsigned(i_value));
                                n_count  = r_count + 7'd1;
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_pos    = AW'(idx);
                                n_val    = DATA_WIDTH'($unsigned(i_value));
                                n_src    = AW'(r_count - 7'd1);
                                n_pend   = 1'b0;
                                n_status = ST_OK;
                                n_state  = S_UP;
                            end
                        end
                        CMD_REMOVE_AT, CMD_REMOVE_FIRST, CMD_REMOVE_LAST: begin
                            if (!in_range) begin
                                n_done   = 1'b1;
                                n_status = ST_INVALID;
                            end else if (idx == r_count - 7'd1) begin
                                n_count  = r_count - 7'd1;
                                n_done   = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_src    = AW'(idx + 7'd1);
                                n_last   = AW'(r_count - 7'd1);
                                n_pend   = 1'b0;
                                n_status = ST_OK;
                                n_state  = S_DN;
                            end
                        end
                        CMD_GET_AT, CMD_GET_FIRST, CMD_GET_LAST: begin
                            if (!in_range) begin
                                n_done   = 1'b1;
                                n_status = ST_INVALID;
                                n_rv     = RV_INVALID;
                            end else begin
                                n_status = ST_OK;
                                n_state  = S_GET;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_UP: begin
                // write the entry read last cycle one slot up, read the next one down
                mem_we = r_pend;
                n_wa   = r_src + AW'(1);
                n_pend = 1'b1;
                if (r_src == r_pos) begin
                    n_state = S_UP_LAST;
                end else begin
                    n_src = r_src - AW'(1);
                end
            end
            S_UP_LAST: begin
                mem_we  = 1'b1;
                n_state = S_PUT;
            end
            S_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos;
                mem_wd  = r_val;
                n_count = r_count + 7'd1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_DN: begin
                mem_we = r_pend;
                n_wa   = r_src - AW'(1);
                n_pend = 1'b1;
                if (r_src == r_last) begin
                    n_state = S_DN_LAST;
                end else begin
                    n_src = r_src + AW'(1);
                end
            end
            S_DN_LAST: begin
                mem_we  = 1'b1;
                n_count = r_count - 7'd1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_GET: begin
                n_rv    = VAL_W'(mem_rd);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_wen) begin
                r_cap <= i_cfg_wdata;
            end
        end
        r_pos    <= n_pos;
        r_src    <= n_src;
        r_wa     <= n_wa;
        r_last   <= n_last;
        r_val    <= n_val;
        r_status <= n_status;
        if (n_done) begin
            r_rv         <= n_rv;
            r_item_count <= n_count;
            r_full       <= (n_count >= eff_cap);
            r_empty      <= (n_count == '0);
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_read_value = $signed(r_rv);
    assign o_item_count = r_item_count;
    assign o_is_full    = r_full;
    assign o_is_empty   = r_empty;

    `BAL_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CAP_LIM)
    `BAL_ASSERT_NEXT(a_request_progress, start && !busy, o_done || busy)
    `BAL_ASSERT_IMPL(a_done_not_busy, o_done, !busy)
    `BAL_ASSERT_IMPL(a_full_status_flag, o_done && (o_status == ST_FULL), o_is_full)

endmodule
`default_nettype wire
